@@ rtl/lzhb_pkg.sv @@
// Shared types and constants for the LZ hash bucket match finder.
// Used by lzhb_hash and lz_hash_bucket_match_finder; no dependencies.
`timescale 1ns / 1ps

package lzhb_pkg;

  localparam int WAYS_DEF            = 4;
  localparam int HASH_BITS_DEF       = 18;
  localparam int SHORT_HASH_BITS_DEF = 16;
  localparam int WINDOW_DEF          = 65536;
  localparam int MAX_MATCH_DEF       = 32;

  // Fibonacci hash multiplier, split in 32-bit halves
  localparam logic [31:0] HASH_MUL_LO = 32'h85EBCA87;
  localparam logic [31:0] HASH_MUL_HI = 32'h9E3779B1;

  localparam int ENT_W = 33;  // valid bit + 32-bit position

  typedef enum logic [2:0] {
    HS_IDLE,
    HS_M0,
    HS_M1,
    HS_M2,
    HS_M3,
    HS_DONE
  } hst_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_LOAD,
    ST_HSTART,
    ST_HWAIT,
    ST_TRD,
    ST_TUSE,
    ST_WAY,
    ST_CRD,
    ST_CCK,
    ST_CDONE,
    ST_SHORT,
    ST_EMIT,
    ST_INEXT
  } st_t;

endpackage

@@ rtl/lz_hash_bucket_match_finder.sv @@
// Top level of the greedy LZ77 match finder with bucket and short hash tables.
// Depends on lzhb_pkg and lzhb_hash.
`timescale 1ns / 1ps

// Greedy LZ77 parser that takes one byte per input request and returns
// literal or (length, distance) results. After reset the block sweeps
// 2**max(HASH_BITS, SHORT_HASH_BITS) addresses of the bucket and short tables
// to empty, with in_ready low; cfg writes are taken during that time. Bytes
// are buffered until MAX_MATCH+7 lie past the parse point, or end_of_stream
// flushes all of them. Each position that is decided or inserted has its 8
// bytes fetched from the window memory, hashed in the shared hash multiplier
// and looked up in the tables, with a write back for an insert. A decision
// also compares byte by byte for each bucket way and for the short candidate,
// each byte pair being one window read. The window is a two-read-port memory,
// WINDOW must be a power of two.
module lz_hash_bucket_match_finder #(
  parameter int WAYS            = lzhb_pkg::WAYS_DEF,
  parameter int HASH_BITS       = lzhb_pkg::HASH_BITS_DEF,
  parameter int SHORT_HASH_BITS = lzhb_pkg::SHORT_HASH_BITS_DEF,
  parameter int WINDOW          = lzhb_pkg::WINDOW_DEF,
  parameter int MAX_MATCH       = lzhb_pkg::MAX_MATCH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_stream,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_is_match,
  output logic [7:0]  out_literal_byte,
  output logic [5:0]  out_match_length,
  output logic [15:0] out_match_distance,
  output logic        out_last_result
);

  localparam int WB     = $clog2(WINDOW);
  localparam int LW     = $clog2(MAX_MATCH + 1);
  localparam int WAYW   = $clog2(WAYS + 1);
  localparam int EW     = lzhb_pkg::ENT_W;
  localparam int BW     = WAYS * EW;
  localparam int ROW_W  = BW + 8;
  localparam int CLR_B  = (HASH_BITS > SHORT_HASH_BITS) ? HASH_BITS : SHORT_HASH_BITS;

  // memories
  logic [7:0]       win_mem [2**WB];
  logic [ROW_W-1:0] bkt_mem [2**HASH_BITS];
  logic [EW-1:0]    sht_mem [2**SHORT_HASH_BITS];

  lzhb_pkg::st_t st_r, st_nxt;

  logic [31:0] br_r, dp_r, p_r, end_r, q_r;
  logic        eos_r, dec_r, sphase_r, tag_filter_r;
  logic [3:0]  ld_cnt_r;
  logic [7:0]  cur_r [8];
  logic [BW-1:0] ents_r;
  logic [EW-1:0] sent_r;
  logic [WAYW-1:0] way_r;
  logic [LW-1:0] best_r, l_r, lim_r;
  logic [15:0] bestd_r, cd_r;
  logic [CLR_B-1:0] clr_r;

  logic              out_valid_r, is_match_r, last_r;
  logic [7:0]        lit_r;
  logic [5:0]        len_out_r;
  logic [15:0]       dist_out_r;

  // memory ports
  logic                       win_we, bkt_we, sht_we;
  logic [WB-1:0]              win_wa, ra_a, ra_b;
  logic [7:0]                 win_qa_r, win_qb_r;
  logic [HASH_BITS-1:0]       bkt_wa, bkt_ra;
  logic [ROW_W-1:0]           bkt_wd, bkt_q_r;
  logic [SHORT_HASH_BITS-1:0] sht_wa, sht_ra;
  logic [EW-1:0]              sht_wd, sht_q_r;

  // hash unit
  logic                       h_start, h_done;
  logic [HASH_BITS-1:0]       lh;
  logic [SHORT_HASH_BITS-1:0] sh;

  // datapath helpers
  logic [31:0]   rem, rem_dp, ld_addr, cmp_qa, cmp_pa, way_d, sht_d, len_end;
  logic [LW-1:0] cap, cap15, len_e;
  logic [7:0]    tag_cur;
  logic          skip, out_free, in_acc;
  logic [BW+EW-1:0] ents_ext;

  function automatic logic [31:0] usable_d(logic [EW-1:0] e, logic [31:0] pos,
                                           logic [31:0] brv);
    logic [31:0] d, age;
    d   = pos - e[31:0];
    age = brv - e[31:0];
    if (!e[32] || d == 32'd0 || d > 32'd65535 || age > 32'(WINDOW)) return 32'd0;
    return d;
  endfunction

  lzhb_hash #(
    .HASH_BITS      (HASH_BITS),
    .SHORT_HASH_BITS(SHORT_HASH_BITS)
  ) u_hash (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (h_start),
    .x_in   ({cur_r[7], cur_r[6], cur_r[5], cur_r[4],
              cur_r[3], cur_r[2], cur_r[1], cur_r[0]}),
    .done   (h_done),
    .long_h (lh),
    .short_h(sh)
  );

  assign rem      = br_r - p_r;
  assign rem_dp   = br_r - dp_r;
  assign cap      = (rem < 32'(MAX_MATCH)) ? rem[LW-1:0] : LW'(MAX_MATCH);
  assign cap15    = (cap < LW'(15)) ? cap : LW'(15);
  assign ld_addr  = p_r + 32'(ld_cnt_r[2:0]);
  assign cmp_qa   = q_r + 32'(l_r);
  assign cmp_pa   = p_r + 32'(l_r);
  assign way_d    = usable_d(ents_r[EW-1:0], p_r, br_r);
  assign sht_d    = usable_d(sent_r, p_r, br_r);
  assign tag_cur  = cur_r[0] ^ cur_r[4];
  assign skip     = tag_filter_r && (WAYS == 1) && (bkt_q_r[ROW_W-1 -: 8] != tag_cur);
  assign len_e    = (best_r >= LW'(4)) ? best_r : LW'(1);
  assign len_end  = p_r + 32'(len_e);
  assign out_free = !out_valid_r || out_ready;
  assign in_acc   = in_valid && in_ready;
  // newest entry enters way 0, the oldest drops off the top
  assign ents_ext = {bkt_q_r[BW-1:0], 1'b1, p_r};

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      lzhb_pkg::ST_CLEAR:  if (clr_r == '1) st_nxt = lzhb_pkg::ST_IDLE;
      lzhb_pkg::ST_IDLE:   if (in_valid) st_nxt = lzhb_pkg::ST_CHECK;
      lzhb_pkg::ST_CHECK: begin
        if (rem_dp == 32'd0 || (!eos_r && rem_dp < 32'(MAX_MATCH + 7)))
          st_nxt = lzhb_pkg::ST_IDLE;
        else
          st_nxt = lzhb_pkg::ST_LOAD;
      end
      lzhb_pkg::ST_LOAD: begin
        if (ld_cnt_r == 4'd8) begin
          if (dec_r)
            st_nxt = (rem < 32'd8) ? lzhb_pkg::ST_EMIT : lzhb_pkg::ST_HSTART;
          else
            st_nxt = (rem < 32'd4) ? lzhb_pkg::ST_INEXT : lzhb_pkg::ST_HSTART;
        end
      end
      lzhb_pkg::ST_HSTART: st_nxt = lzhb_pkg::ST_HWAIT;
      lzhb_pkg::ST_HWAIT:  if (h_done) st_nxt = lzhb_pkg::ST_TRD;
      lzhb_pkg::ST_TRD:    st_nxt = lzhb_pkg::ST_TUSE;
      lzhb_pkg::ST_TUSE:   st_nxt = dec_r ? lzhb_pkg::ST_WAY : lzhb_pkg::ST_INEXT;
      lzhb_pkg::ST_WAY: begin
        if (way_r == WAYW'(WAYS) || !ents_r[EW-1])
          st_nxt = lzhb_pkg::ST_SHORT;
        else if (way_d != 32'd0)
          st_nxt = lzhb_pkg::ST_CRD;
      end
      lzhb_pkg::ST_CRD:
        st_nxt = (l_r == lim_r) ? lzhb_pkg::ST_CDONE : lzhb_pkg::ST_CCK;
      lzhb_pkg::ST_CCK:
        st_nxt = (win_qa_r == win_qb_r) ? lzhb_pkg::ST_CRD : lzhb_pkg::ST_CDONE;
      lzhb_pkg::ST_CDONE:
        st_nxt = sphase_r ? lzhb_pkg::ST_EMIT : lzhb_pkg::ST_WAY;
      lzhb_pkg::ST_SHORT: begin
        if (best_r >= LW'(8) || sht_d == 32'd0)
          st_nxt = lzhb_pkg::ST_EMIT;
        else
          st_nxt = lzhb_pkg::ST_CRD;
      end
      lzhb_pkg::ST_EMIT:   if (out_free) st_nxt = lzhb_pkg::ST_LOAD;
      lzhb_pkg::ST_INEXT:
        st_nxt = (p_r + 32'd1 == end_r) ? lzhb_pkg::ST_CHECK : lzhb_pkg::ST_LOAD;
      default:             st_nxt = lzhb_pkg::ST_IDLE;
    endcase
  end

  // memory controls and handshake outputs
  always_comb begin
    in_ready = 1'b0;
    h_start  = 1'b0;
    win_we   = 1'b0;
    win_wa   = br_r[WB-1:0];
    ra_a     = ld_addr[WB-1:0];
    ra_b     = cmp_pa[WB-1:0];
    bkt_we   = 1'b0;
    bkt_wa   = lh;
    bkt_ra   = lh;
    bkt_wd   = {tag_cur, ents_ext[BW-1:0]};
    sht_we   = 1'b0;
    sht_wa   = sh;
    sht_ra   = sh;
    sht_wd   = {1'b1, p_r};
    case (st_r)
      lzhb_pkg::ST_CLEAR: begin
        bkt_we = 1'b1;
        bkt_wa = clr_r[HASH_BITS-1:0];
        bkt_wd = '0;
        sht_we = 1'b1;
        sht_wa = clr_r[SHORT_HASH_BITS-1:0];
        sht_wd = '0;
      end
      lzhb_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        win_we   = in_valid;
      end
      lzhb_pkg::ST_HSTART: h_start = 1'b1;
      lzhb_pkg::ST_TUSE: begin
        if (!dec_r) begin
          bkt_we = (rem >= 32'd8);
          sht_we = 1'b1;
        end
      end
      lzhb_pkg::ST_CRD: ra_a = cmp_qa[WB-1:0];
      default: ;
    endcase
  end

  // memories: one write port, registered reads
  always_ff @(posedge clk) begin
    if (win_we) win_mem[win_wa] <= in_data_byte;
    win_qa_r <= win_mem[ra_a];
    win_qb_r <= win_mem[ra_b];
  end

  always_ff @(posedge clk) begin
    if (bkt_we) bkt_mem[bkt_wa] <= bkt_wd;
    bkt_q_r <= bkt_mem[bkt_ra];
  end

  always_ff @(posedge clk) begin
    if (sht_we) sht_mem[sht_wa] <= sht_wd;
    sht_q_r <= sht_mem[sht_ra];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= lzhb_pkg::ST_CLEAR;
      clr_r        <= '0;
      br_r         <= '0;
      dp_r         <= '0;
      tag_filter_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (cfg_wr_en) tag_filter_r <= cfg_wr_data;
      if (st_r == lzhb_pkg::ST_CLEAR) clr_r <= clr_r + CLR_B'(1);
      if (in_acc) br_r <= br_r + 32'd1;
      // load a new result when free, else drop the held one once taken
      if (st_r == lzhb_pkg::ST_EMIT && out_free) begin
        out_valid_r <= 1'b1;
        dp_r        <= len_end;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_acc) eos_r <= in_end_of_stream;
    case (st_r)
      lzhb_pkg::ST_CHECK: begin
        p_r      <= dp_r;
        dec_r    <= 1'b1;
        ld_cnt_r <= '0;
        best_r   <= '0;
        bestd_r  <= '0;
      end
      lzhb_pkg::ST_LOAD: begin
        if (ld_cnt_r != 4'd8) ld_cnt_r <= ld_cnt_r + 4'd1;
        if (ld_cnt_r != 4'd0) cur_r[3'(ld_cnt_r - 4'd1)] <= win_qa_r;
      end
      lzhb_pkg::ST_TUSE: begin
        ents_r <= bkt_q_r[BW-1:0];
        sent_r <= sht_q_r;
        way_r  <= skip ? WAYW'(WAYS) : '0;
      end
      lzhb_pkg::ST_WAY: begin
        if (!(way_r == WAYW'(WAYS) || !ents_r[EW-1])) begin
          if (way_d == 32'd0) begin
            ents_r <= ents_r >> EW;
            way_r  <= way_r + WAYW'(1);
          end else begin
            q_r      <= ents_r[31:0];
            cd_r     <= way_d[15:0];
            lim_r    <= cap;
            l_r      <= '0;
            sphase_r <= 1'b0;
          end
        end
      end
      lzhb_pkg::ST_CCK: if (win_qa_r == win_qb_r) l_r <= l_r + LW'(1);
      lzhb_pkg::ST_CDONE: begin
        if (sphase_r) begin
          if (l_r >= LW'(4)) begin
            best_r  <= l_r;
            bestd_r <= cd_r;
          end
        end else begin
          // longest wins, nearer on a tie
          if (l_r >= LW'(8) && (l_r > best_r || (l_r == best_r && cd_r < bestd_r))) begin
            best_r  <= l_r;
            bestd_r <= cd_r;
          end
          ents_r <= ents_r >> EW;
          way_r  <= way_r + WAYW'(1);
        end
      end
      lzhb_pkg::ST_SHORT: begin
        q_r      <= sent_r[31:0];
        cd_r     <= sht_d[15:0];
        lim_r    <= cap15;
        l_r      <= '0;
        sphase_r <= 1'b1;
      end
      lzhb_pkg::ST_EMIT: begin
        if (out_free) begin
          is_match_r <= (best_r >= LW'(4));
          lit_r      <= (best_r >= LW'(4)) ? 8'd0 : cur_r[0];
          len_out_r  <= (best_r >= LW'(4)) ? 6'(best_r) : 6'd0;
          dist_out_r <= (best_r >= LW'(4)) ? bestd_r : 16'd0;
          last_r     <= eos_r && (len_end == br_r);
          end_r      <= len_end;
          dec_r      <= 1'b0;
          ld_cnt_r   <= '0;
        end
      end
      lzhb_pkg::ST_INEXT: begin
        p_r      <= p_r + 32'd1;
        ld_cnt_r <= '0;
      end
      default: ;
    endcase
  end

  assign out_valid          = out_valid_r;
  assign out_is_match       = is_match_r;
  assign out_literal_byte   = lit_r;
  assign out_match_length   = len_out_r;
  assign out_match_distance = dist_out_r;
  assign out_last_result    = last_r;

  // parse point never falls a full lookahead behind while waiting for bytes
  a_lookahead: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == lzhb_pkg::ST_IDLE |-> (br_r - dp_r) < 32'(MAX_MATCH + 7))
    else $error("pending bytes exceed lookahead in idle");

  a_match_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_match |->
      out_match_length >= 6'd4 && out_match_length <= 6'(MAX_MATCH) &&
      out_match_distance != 16'd0 && out_literal_byte == 8'd0)
    else $error("match result out of range");

  a_literal_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_match |-> out_match_length == 6'd0 && out_match_distance == 16'd0)
    else $error("literal result carries match fields");

  a_emit_advance: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == lzhb_pkg::ST_EMIT && out_free |=> dp_r == end_r && out_valid_r)
    else $error("parse point not advanced on emit");

endmodule

@@ rtl/lzhb_hash.sv @@
// Multi-cycle long and short hash unit built around one 32x32 multiplier.
// Depends on lzhb_pkg.
`timescale 1ns / 1ps

module lzhb_hash #(
  parameter int HASH_BITS       = lzhb_pkg::HASH_BITS_DEF,
  parameter int SHORT_HASH_BITS = lzhb_pkg::SHORT_HASH_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [63:0]                x_in,
  output logic                       done,
  output logic [HASH_BITS-1:0]       long_h,
  output logic [SHORT_HASH_BITS-1:0] short_h
);

  lzhb_pkg::hst_t hst_r, hst_nxt;
  logic [31:0] lo_r, hi_r, raw_lo_r, acc_r;
  logic [63:0] prod_r;
  logic [31:0] op_a, op_b;
  logic        mul_en;

  always_comb begin
    hst_nxt = hst_r;
    case (hst_r)
      lzhb_pkg::HS_IDLE: if (start) hst_nxt = lzhb_pkg::HS_M0;
      lzhb_pkg::HS_M0:   hst_nxt = lzhb_pkg::HS_M1;
      lzhb_pkg::HS_M1:   hst_nxt = lzhb_pkg::HS_M2;
      lzhb_pkg::HS_M2:   hst_nxt = lzhb_pkg::HS_M3;
      lzhb_pkg::HS_M3:   hst_nxt = lzhb_pkg::HS_DONE;
      lzhb_pkg::HS_DONE: hst_nxt = lzhb_pkg::HS_IDLE;
      default:           hst_nxt = lzhb_pkg::HS_IDLE;
    endcase
  end

  always_comb begin
    op_a   = lo_r;
    op_b   = lzhb_pkg::HASH_MUL_LO;
    mul_en = 1'b0;
    done   = 1'b0;
    case (hst_r)
      lzhb_pkg::HS_M0: begin
        mul_en = 1'b1;
      end
      lzhb_pkg::HS_M1: begin
        op_a   = hi_r;
        mul_en = 1'b1;
      end
      lzhb_pkg::HS_M2: begin
        op_b   = lzhb_pkg::HASH_MUL_HI;
        mul_en = 1'b1;
      end
      lzhb_pkg::HS_M3: begin
        op_a   = raw_lo_r;
        op_b   = lzhb_pkg::HASH_MUL_HI;
        mul_en = 1'b1;
      end
      lzhb_pkg::HS_DONE: done = 1'b1;
      default: ;
    endcase
  end

  assign long_h  = acc_r[31 -: HASH_BITS];
  assign short_h = prod_r[31 -: SHORT_HASH_BITS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hst_r <= lzhb_pkg::HS_IDLE;
    end else begin
      hst_r <= hst_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (hst_r == lzhb_pkg::HS_IDLE && start) begin
      lo_r     <= x_in[31:0] ^ x_in[63:32];
      hi_r     <= x_in[63:32];
      raw_lo_r <= x_in[31:0];
    end
    if (mul_en) prod_r <= op_a * op_b;
    // upper word of the 64-bit product is built from three partial products
    case (hst_r)
      lzhb_pkg::HS_M1: acc_r <= prod_r[63:32];
      lzhb_pkg::HS_M2: acc_r <= acc_r + prod_r[31:0];
      lzhb_pkg::HS_M3: acc_r <= acc_r + prod_r[31:0];
      default: ;
    endcase
  end

endmodule

@@ sim/tb.sv @@
// Self-checking testbench for lz_hash_bucket_match_finder: table-driven
// directed streams, then random streams, checked by an in-file parser or a
// typed row's answer. Depends on lzhb_pkg and the RTL of lz_hash_bucket_match_finder.
`timescale 1ns / 1ps

module tb;

  localparam int WAYS    = lzhb_pkg::WAYS_DEF;
  localparam int HBITS   = lzhb_pkg::HASH_BITS_DEF;
  localparam int SHBITS  = lzhb_pkg::SHORT_HASH_BITS_DEF;
  localparam int WIN     = lzhb_pkg::WINDOW_DEF;
  localparam int WINB    = $clog2(WIN);
  localparam int MAXLEN  = lzhb_pkg::MAX_MATCH_DEF;
  localparam int RAND_BYTES = 235;
  // settle time after the last token: covers inserting a whole match
  localparam int DRAIN_CYCLES = 2000;
  localparam int HOLD_CYCLES  = 3000;

  typedef struct {
    bit        is_match;
    bit [7:0]  lit;
    bit [5:0]  len;
    bit [15:0] back_dist;
    bit        last;
  } token_t;

  typedef struct {
    bit [7:0] b;
    bit       eos;
    bit       typed;
    token_t   tok;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_wr_data = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_end_of_stream = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_is_match;
  logic [7:0]  out_literal_byte;
  logic [5:0]  out_match_length;
  logic [15:0] out_match_distance;
  logic        out_last_result;

  always #10 clk = ~clk;

  lz_hash_bucket_match_finder DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_data_byte(in_data_byte), .in_end_of_stream(in_end_of_stream),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_is_match(out_is_match), .out_literal_byte(out_literal_byte),
    .out_match_length(out_match_length), .out_match_distance(out_match_distance),
    .out_last_result(out_last_result)
  );

  // ---------------------------------------------------------------------------
  // Parser mirror: history, both hash tables, tags, counters and the register.
  // The bucket table is sparse since only a few hundred positions get inserted.
  // ---------------------------------------------------------------------------
  bit [7:0]  hist_win [WIN];
  bit [32:0] bucket_mem [int unsigned];
  bit [32:0] short_mem [1 << SHBITS];
  bit [7:0]  tag_mem [1 << HBITS];
  bit [31:0] rx_count;
  bit [31:0] parse_ptr;
  bit        tag_filter_q;

  token_t expected_tokens [$];
  int     error_count;
  int     tokens_seen;

  // values the driver hands to the monitor along with each request
  bit     row_typed;
  token_t row_token;

  function automatic bit [7:0] hbyte(bit [31:0] p);
    return hist_win[p[WINB-1:0]];
  endfunction

  function automatic bit [32:0] bucket_rd(int unsigned idx);
    return bucket_mem.exists(idx) ? bucket_mem[idx] : 33'd0;
  endfunction

  function automatic bit [HBITS-1:0] long_hash(bit [31:0] p);
    bit [63:0] x;
    x = 64'd0;
    for (int i = 0; i < 8; i++) x |= {56'd0, hbyte(p + i)} << (8 * i);
    x ^= x >> 32;
    x = x * 64'h9E3779B185EBCA87;
    return HBITS'(x >> (64 - HBITS));
  endfunction

  function automatic bit [SHBITS-1:0] short_hash(bit [31:0] p);
    bit [63:0] x;
    x = 64'd0;
    for (int i = 0; i < 4; i++) x |= {56'd0, hbyte(p + i)} << (8 * i);
    x = (x * 64'h9E3779B1) & 64'hFFFFFFFF;
    return SHBITS'(x >> (32 - SHBITS));
  endfunction

  function automatic bit [7:0] tag_at(bit [31:0] p);
    return hbyte(p) ^ hbyte(p + 4);
  endfunction

  // distance to a candidate, zero when empty, not behind, too far or aged out
  function automatic bit [31:0] cand_dist(bit [32:0] ent, bit [31:0] pos);
    bit [31:0] d;
    if (!ent[32]) return 0;
    d = pos - ent[31:0];
    if (d == 0 || d > 65535) return 0;
    if (rx_count - ent[31:0] > WIN) return 0;
    return d;
  endfunction

  function automatic bit [31:0] run_len(bit [31:0] q, bit [31:0] pos, bit [31:0] lim);
    bit [31:0] l;
    l = 0;
    while (l < lim && hbyte(q + l) == hbyte(pos + l)) l++;
    return l;
  endfunction

  function automatic void index_pos(bit [31:0] p);
    bit [31:0] rem;
    bit [HBITS-1:0] h;
    rem = rx_count - p;
    if (rem >= 8) begin
      h = long_hash(p);
      for (int i = WAYS - 1; i > 0; i--) bucket_mem[h * WAYS + i] = bucket_rd(h * WAYS + i - 1);
      bucket_mem[h * WAYS] = {1'b1, p};
      if (WAYS == 1) tag_mem[h] = tag_at(p);
      short_mem[short_hash(p)] = {1'b1, p};
    end else if (rem >= 4) begin
      short_mem[short_hash(p)] = {1'b1, p};
    end
  endfunction

  // best match at pos: returns length (0 for none) and its distance
  function automatic bit [31:0] best_match(bit [31:0] pos, output bit [31:0] mdist);
    bit [31:0] rem, cap, best, bestd, d, l;
    bit [HBITS-1:0] h;
    bit [32:0] ent;
    rem = rx_count - pos;
    cap = rem < MAXLEN ? rem : MAXLEN;
    best = 0;
    bestd = 0;
    mdist = 0;
    if (rem < 8) return 0;
    h = long_hash(pos);
    if (!(tag_filter_q && WAYS == 1 && tag_mem[h] != tag_at(pos))) begin
      for (int i = 0; i < WAYS; i++) begin
        ent = bucket_rd(h * WAYS + i);
        if (!ent[32]) break;
        d = cand_dist(ent, pos);
        if (d != 0) begin
          l = run_len(pos - d, pos, cap);
          if (l >= 8 && (l > best || (l == best && d < bestd))) begin
            best = l;
            bestd = d;
          end
        end
      end
    end
    if (best < 8) begin
      d = cand_dist(short_mem[short_hash(pos)], pos);
      if (d != 0) begin
        l = run_len(pos - d, pos, cap < 15 ? cap : 15);
        if (l >= 4) begin
          best = l;
          bestd = d;
        end
      end
    end
    if (best < 4) return 0;
    mdist = bestd;
    return best;
  endfunction

  // take one byte, return the tokens it releases
  function automatic void parse_byte(bit [7:0] b, bit eos, ref token_t toks[$]);
    bit [31:0] rem, len, mdist;
    token_t t;
    hist_win[rx_count[WINB-1:0]] = b;
    rx_count++;
    while (toks.size() < 64) begin
      rem = rx_count - parse_ptr;
      if (rem == 0) break;
      if (!eos && rem < MAXLEN + 7) break;
      len = best_match(parse_ptr, mdist);
      t = '{default: 0};
      if (len >= 4) begin
        t.is_match = 1'b1;
        t.len = len[5:0];
        t.back_dist = mdist[15:0];
      end else begin
        len = 1;
        t.lit = hbyte(parse_ptr);
      end
      toks.insert(toks.size(), t);
      for (bit [31:0] k = 0; k < len; k++) index_pos(parse_ptr + k);
      parse_ptr += len;
    end
    if (eos && toks.size() > 0) toks[toks.size() - 1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: predict on each accepted request, check each accepted token.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    token_t toks [$];
    token_t want;
    if (rst_n) begin
      if (cfg_wr_en) tag_filter_q <= cfg_wr_data;
      if (in_valid && in_ready) begin
        toks.delete();
        parse_byte(in_data_byte, in_end_of_stream, toks);
        // rows with a hand-written answer replace the predicted one
        if (row_typed) begin
          toks.delete();
          toks.insert(0, row_token);
        end
        foreach (toks[i]) expected_tokens.insert(expected_tokens.size(), toks[i]);
      end
      if (out_valid && out_ready) begin
        tokens_seen++;
        if (expected_tokens.size() == 0) begin
          $error("token with nothing expected: match=%0d lit=%0h len=%0d dist=%0d",
                 out_is_match, out_literal_byte, out_match_length, out_match_distance);
          error_count++;
        end else begin
          want = expected_tokens.pop_front();
          if (out_is_match !== want.is_match) begin
            $error("is_match: expected %0d, got %0d", want.is_match, out_is_match);
            error_count++;
          end
          if (out_literal_byte !== want.lit) begin
            $error("literal_byte: expected %0h, got %0h", want.lit, out_literal_byte);
            error_count++;
          end
          if (out_match_length !== want.len) begin
            $error("match_length: expected %0d, got %0d", want.len, out_match_length);
            error_count++;
          end
          if (out_match_distance !== want.back_dist) begin
            $error("match_distance: expected %0d, got %0d", want.back_dist,
                   out_match_distance);
            error_count++;
          end
          if (out_last_result !== want.last) begin
            $error("last_result: expected %0d, got %0d", want.last, out_last_result);
            error_count++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, ready-only stretches, and one long hold-off once
  // the block is busy so that its input backs up.
  // ---------------------------------------------------------------------------
  initial begin
    int  open_run;
    bit  held;
    open_run = 0;
    held = 0;
    forever begin
      @(negedge clk);
      if (!held && tokens_seen >= 40 && in_valid) begin
        held = 1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else if (open_run > 0) begin
        open_run--;
        out_ready <= 1'b1;
      end else if ($urandom_range(0, 29) == 0) begin
        open_run = $urandom_range(20, 80);
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 2) != 0);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------
  int burst_left;
  bit [7:0] sent_bytes [$];

  task automatic offer(input bit [7:0] b, input bit eos, input bit typed, input token_t t);
    if (burst_left == 0) begin
      repeat ($urandom_range(1, 8)) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_end_of_stream <= eos;
    row_typed = typed;
    row_token = t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
    sent_bytes.insert(sent_bytes.size(), b);
  endtask

  // hold the input idle, drain every token, let pending inserts finish
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_filter(input bit v);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // one random stream: repeating patterns, copies of earlier data, or noise
  task automatic random_stream(inout int budget);
    int len, mode, period, back;
    bit [7:0] pat [16];
    bit [7:0] b;
    token_t none;
    none = '{default: 0};
    len = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 7) : $urandom_range(8, 70);
    if (len > budget) len = budget;
    mode = $urandom_range(0, 3);
    period = $urandom_range(1, 16);
    foreach (pat[i]) pat[i] = 8'($urandom_range(0, 255));
    for (int i = 0; i < len; i++) begin
      case (mode)
        0: b = 8'($urandom_range(0, 255));
        1: b = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 255)) : pat[i % period];
        default: begin
          back = $urandom_range(1, sent_bytes.size() < 200 ? sent_bytes.size() : 200);
          b = (sent_bytes.size() == 0 || $urandom_range(0, 24) == 0) ?
              8'($urandom_range(0, 255)) : sent_bytes[sent_bytes.size() - back];
        end
      endcase
      offer(b, i == len - 1, 1'b0, none);
      budget--;
    end
  endtask

  initial begin
    row_t rows [$];
    token_t none;
    token_t lit;
    int budget;
    string abcd;
    none = '{default: 0};
    error_count = 0;
    tokens_seen = 0;
    burst_left = 0;
    rx_count = 0;
    parse_ptr = 0;
    tag_filter_q = 1'b0;
    row_typed = 1'b0;
    row_token = none;

    // single-byte streams at both byte extremes: one literal, flagged last
    lit = '{is_match: 0, lit: 8'h00, len: 0, back_dist: 0, last: 1};
    rows.insert(rows.size(), row_t'{8'h00, 1'b1, 1'b1, lit});
    lit.lit = 8'hFF;
    rows.insert(rows.size(), row_t'{8'hFF, 1'b1, 1'b1, lit});
    // periodic stream: long bucket match once the first period is indexed
    abcd = "ABCDABCDABCDABCDABCDA";
    for (int i = 0; i < abcd.len(); i++)
      rows.insert(rows.size(), row_t'{abcd[i], i == abcd.len() - 1, 1'b0, none});
    // short stream right after a flush
    rows.insert(rows.size(), row_t'{8'h5A, 1'b0, 1'b0, none});
    rows.insert(rows.size(), row_t'{8'h80, 1'b1, 1'b0, none});

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    // the block takes register writes during its table clear
    write_filter(1'b1);

    foreach (rows[i]) offer(rows[i].b, rows[i].eos, rows[i].typed, rows[i].tok);
    row_typed = 1'b0;
    settle();

    write_filter(1'b0);
    budget = RAND_BYTES / 2;
    while (budget > 0) random_stream(budget);
    settle();

    write_filter(1'b1);
    budget = RAND_BYTES - RAND_BYTES / 2;
    while (budget > 0) random_stream(budget);
    settle();

    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // allow many times a slow run, the table clear included
  initial begin
    #60ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
